// File: rtl/trdt_pkg.sv
// Shared types and constants for the triangle rasterizer with depth test.
// Used by trdt_ctrl, trdt_datapath and triangle_raster_depth_test.
package trdt_pkg;

   // Field widths fixed by the transaction format.
   localparam int XW        = 10;
   localparam int YW        = 9;
   localparam int CMD_W     = 2;
   localparam int COLOR_W   = 24;
   localparam int CSR_IDX_W = 2;

   // Edge function values stay below 2^21 in magnitude; one spare bit.
   localparam int EDGE_W = 23;
   // Signed coordinate differences.
   localparam int DIFF_W = 12;
   // Step index for setup, multiply and divide sequencing (depth up to 32 bits).
   localparam int STEP_W = 5;

   localparam int DEF_MAX_WIDTH  = 640;
   localparam int DEF_MAX_HEIGHT = 480;
   localparam int DEF_DEPTH_BITS = 24;

   localparam logic [XW-1:0] WIDTH_RESET  = 10'd640;
   localparam logic [YW-1:0] HEIGHT_RESET = 9'd480;
   localparam int            FAR_RESET    = 8192000;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FAR    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOX,
      ST_SETUP,
      ST_CHECK,
      ST_PIX,
      ST_MUL,
      ST_DIV,
      ST_TEST,
      ST_STEP,
      ST_CLEAR,
      ST_DONE
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_BOX,
      OP_SETUP,
      OP_PIX,
      OP_MUL,
      OP_DIV,
      OP_TEST,
      OP_STEP,
      OP_CLEAR,
      OP_RSP
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [STEP_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] code;
      logic             skip;
      logic             rd_ok;
      logic             covered;
      logic             row_end;
      logic             box_end;
      logic             clr_end;
   } dp_status_type;

endpackage

// File: rtl/triangle_raster_depth_test.sv
// Top level of the triangle rasterizer with depth test.
// Depends on trdt_pkg, trdt_ctrl and trdt_datapath.
//
// Usage:
//   Commands arrive as transactions on the req_ channel (valid/ready) and each
//   produces exactly one response transaction on the rsp_ channel.
//   Command clear fills every color entry with req_fill_color and every depth
//   entry with the far_depth register. Command draw rasterizes the triangle
//   a, b, c with flat color req_fill_color, writing a pixel only where its
//   interpolated depth is smaller than the stored one, and returns the number
//   of pixels written. Command read returns the stored color and depth of the
//   pixel at (req_ax, req_ay), or zeros outside the active screen.
//   The csr_ port writes screen_width (index 0), screen_height (1) and
//   far_depth (2); write it only while the block is idle.
// Timing:
//   One transaction is processed at a time. A clear writes one store entry per
//   cycle. A draw runs its setup, then steps over every pixel of the clamped
//   bounding box; a pixel that passes coverage also goes through the weight
//   multiply and the one-bit-per-cycle divider before its depth test.
// Reset and stalls:
//   Reset returns the controller to idle and the registers to 640 x 480 with a
//   far depth of 500.0; the stores are undefined until the first clear.
//   A finished response waits in the output register while the next command is
//   accepted and processed; the block stalls only when that next response is
//   ready and the previous one has still not been taken.
module triangle_raster_depth_test #(
   parameter int MAX_WIDTH  = trdt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = trdt_pkg::DEF_MAX_HEIGHT,
   parameter int DEPTH_BITS = trdt_pkg::DEF_DEPTH_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [trdt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [DEPTH_BITS-1:0]          csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [trdt_pkg::CMD_W-1:0]     req_command,
   input  logic [trdt_pkg::XW-1:0]        req_ax,
   input  logic [trdt_pkg::YW-1:0]        req_ay,
   input  logic [DEPTH_BITS-1:0]          req_az,
   input  logic [trdt_pkg::XW-1:0]        req_bx,
   input  logic [trdt_pkg::YW-1:0]        req_by_row,
   input  logic [DEPTH_BITS-1:0]          req_bz,
   input  logic [trdt_pkg::XW-1:0]        req_cx,
   input  logic [trdt_pkg::YW-1:0]        req_cy,
   input  logic [DEPTH_BITS-1:0]          req_cz,
   input  logic [trdt_pkg::COLOR_W-1:0]   req_fill_color,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] rsp_pixels_written,
   output logic [trdt_pkg::COLOR_W-1:0]   rsp_read_color,
   output logic [DEPTH_BITS-1:0]          rsp_read_depth
);

   // Commands flow from the controller to the datapath; status flows back.
   trdt_pkg::dp_cmd_type    dp_cmd;
   trdt_pkg::dp_status_type dp_status;

   trdt_ctrl #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (dp_status),
      .cmd         (dp_cmd)
   );

   // The datapath holds the configuration registers, the walk state and
   // both stores.
   trdt_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_command        (req_command),
      .req_ax             (req_ax),
      .req_ay             (req_ay),
      .req_az             (req_az),
      .req_bx             (req_bx),
      .req_by_row         (req_by_row),
      .req_bz             (req_bz),
      .req_cx             (req_cx),
      .req_cy             (req_cy),
      .req_cz             (req_cz),
      .req_fill_color     (req_fill_color),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .rsp_pixels_written (rsp_pixels_written),
      .rsp_read_color     (rsp_read_color),
      .rsp_read_depth     (rsp_read_depth)
   );

endmodule

// File: rtl/trdt_ctrl.sv
// Sequencing state machine for the triangle rasterizer.
// Depends on trdt_pkg; drives trdt_datapath through dp_cmd_type commands.
module trdt_ctrl #(
   parameter int DEPTH_BITS = trdt_pkg::DEF_DEPTH_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [trdt_pkg::CMD_W-1:0] req_command,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  trdt_pkg::dp_status_type status,
   output trdt_pkg::dp_cmd_type    cmd
);

   localparam logic [trdt_pkg::STEP_W-1:0] SETUP_LAST = trdt_pkg::STEP_W'(3);
   localparam logic [trdt_pkg::STEP_W-1:0] MUL_LAST   = trdt_pkg::STEP_W'(2);
   localparam logic [trdt_pkg::STEP_W-1:0] DIV_FIRST  = trdt_pkg::STEP_W'(DEPTH_BITS - 1);

   trdt_pkg::ctl_state_type state_ff, state_in;
   logic [trdt_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trdt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = trdt_pkg::OP_NONE;
      cmd.idx      = cnt_ff;
      unique case (state_ff)
         trdt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = trdt_pkg::OP_LOAD;
               unique case (req_command) inside
                  trdt_pkg::CMD_CLEAR:                    state_in = trdt_pkg::ST_CLEAR;
                  trdt_pkg::CMD_DRAW, trdt_pkg::CMD_READ: state_in = trdt_pkg::ST_BOX;
                  default:                                state_in = trdt_pkg::ST_DONE;
               endcase
            end
         end
         trdt_pkg::ST_BOX: begin
            cmd.op   = trdt_pkg::OP_BOX;
            cnt_in   = '0;
            state_in = trdt_pkg::ST_SETUP;
         end
         trdt_pkg::ST_SETUP: begin
            cmd.op = trdt_pkg::OP_SETUP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SETUP_LAST) begin
               state_in = (status.code == trdt_pkg::CMD_READ) ? trdt_pkg::ST_DONE
                                                               : trdt_pkg::ST_CHECK;
            end
         end
         trdt_pkg::ST_CHECK: begin
            state_in = status.skip ? trdt_pkg::ST_DONE : trdt_pkg::ST_PIX;
         end
         trdt_pkg::ST_PIX: begin
            cmd.op = trdt_pkg::OP_PIX;
            cnt_in = '0;
            state_in = status.covered ? trdt_pkg::ST_MUL : trdt_pkg::ST_STEP;
         end
         trdt_pkg::ST_MUL: begin
            cmd.op = trdt_pkg::OP_MUL;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = DIV_FIRST;
               state_in = trdt_pkg::ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         trdt_pkg::ST_DIV: begin
            cmd.op = trdt_pkg::OP_DIV;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = trdt_pkg::ST_TEST;
            end
         end
         trdt_pkg::ST_TEST: begin
            cmd.op   = trdt_pkg::OP_TEST;
            state_in = trdt_pkg::ST_STEP;
         end
         trdt_pkg::ST_STEP: begin
            cmd.op = trdt_pkg::OP_STEP;
            state_in = (status.row_end && status.box_end) ? trdt_pkg::ST_DONE
                                                          : trdt_pkg::ST_PIX;
         end
         trdt_pkg::ST_CLEAR: begin
            cmd.op = trdt_pkg::OP_CLEAR;
            if (status.clr_end) begin
               state_in = trdt_pkg::ST_DONE;
            end
         end
         trdt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = trdt_pkg::OP_RSP;
               rsp_valid_in = 1'b1;
               state_in     = trdt_pkg::ST_IDLE;
            end
         end
         default: state_in = trdt_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/trdt_datapath.sv
// Datapath of the triangle rasterizer: configuration, vertex and edge registers,
// multiply-accumulate, restoring divider and the color and depth memories.
// Depends on trdt_pkg; sequenced by trdt_ctrl.
module trdt_datapath #(
   parameter int MAX_WIDTH  = trdt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = trdt_pkg::DEF_MAX_HEIGHT,
   parameter int DEPTH_BITS = trdt_pkg::DEF_DEPTH_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [trdt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [DEPTH_BITS-1:0]            csr_wdata,
   input  logic [trdt_pkg::CMD_W-1:0]       req_command,
   input  logic [trdt_pkg::XW-1:0]          req_ax,
   input  logic [trdt_pkg::YW-1:0]          req_ay,
   input  logic [DEPTH_BITS-1:0]            req_az,
   input  logic [trdt_pkg::XW-1:0]          req_bx,
   input  logic [trdt_pkg::YW-1:0]          req_by_row,
   input  logic [DEPTH_BITS-1:0]            req_bz,
   input  logic [trdt_pkg::XW-1:0]          req_cx,
   input  logic [trdt_pkg::YW-1:0]          req_cy,
   input  logic [DEPTH_BITS-1:0]            req_cz,
   input  logic [trdt_pkg::COLOR_W-1:0]     req_fill_color,
   input  trdt_pkg::dp_cmd_type             cmd,
   output trdt_pkg::dp_status_type          status,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] rsp_pixels_written,
   output logic [trdt_pkg::COLOR_W-1:0]     rsp_read_color,
   output logic [DEPTH_BITS-1:0]            rsp_read_depth
);

   localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(STORE);
   localparam int CNT_W = $clog2(STORE + 1);
   localparam int EW    = trdt_pkg::EDGE_W;
   localparam int DW    = trdt_pkg::DIFF_W;
   localparam int XW    = trdt_pkg::XW;
   localparam int YW    = trdt_pkg::YW;
   localparam int NW    = DEPTH_BITS + EW;
   localparam int PW    = DEPTH_BITS + EW - 1;
   localparam logic [DEPTH_BITS-1:0] FAR_INIT = DEPTH_BITS'(trdt_pkg::FAR_RESET);
   localparam logic [AW-1:0]         CLR_LAST = AW'(STORE - 1);

   // Configuration registers.
   logic [XW-1:0]         width_ff;
   logic [YW-1:0]         height_ff;
   logic [DEPTH_BITS-1:0] far_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= trdt_pkg::WIDTH_RESET;
         height_ff <= trdt_pkg::HEIGHT_RESET;
         far_ff    <= FAR_INIT;
      end else if (csr_we) begin
         unique case (csr_index)
            trdt_pkg::REG_WIDTH:  width_ff  <= csr_wdata[XW-1:0];
            trdt_pkg::REG_HEIGHT: height_ff <= csr_wdata[YW-1:0];
            trdt_pkg::REG_FAR:    far_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Active size saturates at the store dimensions.
   logic [XW-1:0] wact;
   logic [YW-1:0] hact;
   assign wact = (int'(width_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH) : width_ff;
   assign hact = (int'(height_ff) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : height_ff;

   // Transaction registers.
   logic [trdt_pkg::CMD_W-1:0]   code_ff;
   logic [XW-1:0]                vx_ff [3];
   logic [YW-1:0]                vy_ff [3];
   logic [DEPTH_BITS-1:0]        vz_ff [3];
   logic [trdt_pkg::COLOR_W-1:0] color_ff;

   // Box, walk position and size snapshot.
   logic [XW-1:0] minx_ff, maxx_ff, px_ff, w_ff;
   logic [YW-1:0] miny_ff, maxy_ff, py_ff, h_ff;
   logic [AW-1:0] row_base_ff, clr_ff;

   // Edge values.
   logic signed [EW-1:0] total_ff;
   logic signed [EW-1:0] e_ff [3];
   logic signed [EW-1:0] erow_ff [3];
   logic signed [EW-1:0] dxs [3];
   logic signed [EW-1:0] dys [3];

   logic [NW-1:0]          acc_ff;
   logic [DEPTH_BITS-1:0]  q_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [trdt_pkg::COLOR_W-1:0] rd_color_ff;
   logic [DEPTH_BITS-1:0]  rd_depth_ff;

   // Bounding box.
   logic [XW-1:0] bminx, bmaxx, bmaxx_c;
   logic [YW-1:0] bminy, bmaxy, bmaxy_c;

   always_comb begin
      bminx = vx_ff[0];
      bmaxx = vx_ff[0];
      bminy = vy_ff[0];
      bmaxy = vy_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (vx_ff[i] < bminx) bminx = vx_ff[i];
         if (vx_ff[i] > bmaxx) bmaxx = vx_ff[i];
         if (vy_ff[i] < bminy) bminy = vy_ff[i];
         if (vy_ff[i] > bmaxy) bmaxy = vy_ff[i];
      end
      bmaxx_c = (bmaxx >= wact) ? wact - 1'b1 : bmaxx;
      bmaxy_c = (bmaxy >= hact) ? hact - 1'b1 : bmaxy;
   end

   // Edge steps: edge i runs from vertex P to Q with (P,Q) = (b,c), (c,a), (a,b).
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dxs[i] = EW'($signed({1'b0, vy_ff[(i + 1) % 3]}) - $signed({1'b0, vy_ff[(i + 2) % 3]}));
         dys[i] = EW'($signed({1'b0, vx_ff[(i + 2) % 3]}) - $signed({1'b0, vx_ff[(i + 1) % 3]}));
      end
   end

   // Setup evaluation of one edge function.
   logic [XW-1:0] sp_x, sq_x, st_x;
   logic [YW-1:0] sp_y, sq_y, st_y;
   logic signed [DW-1:0]   d_tx, d_pq_y, d_ty, d_qp_x;
   logic signed [2*DW-1:0] edge_sum;
   logic signed [EW-1:0]   edge_val;

   always_comb begin
      st_x = px_ff;
      st_y = py_ff;
      sp_x = vx_ff[1];
      sp_y = vy_ff[1];
      sq_x = vx_ff[2];
      sq_y = vy_ff[2];
      case (cmd.idx)
         trdt_pkg::STEP_W'(0): begin
            st_x = vx_ff[0];
            st_y = vy_ff[0];
         end
         trdt_pkg::STEP_W'(2): begin
            sp_x = vx_ff[2];
            sp_y = vy_ff[2];
            sq_x = vx_ff[0];
            sq_y = vy_ff[0];
         end
         trdt_pkg::STEP_W'(3): begin
            sp_x = vx_ff[0];
            sp_y = vy_ff[0];
            sq_x = vx_ff[1];
            sq_y = vy_ff[1];
         end
         default: ;
      endcase
      d_tx     = $signed({2'b0, st_x}) - $signed({2'b0, sp_x});
      d_pq_y   = $signed({3'b0, sp_y}) - $signed({3'b0, sq_y});
      d_ty     = $signed({3'b0, st_y}) - $signed({3'b0, sp_y});
      d_qp_x   = $signed({2'b0, sq_x}) - $signed({2'b0, sp_x});
      edge_sum = d_tx * d_pq_y + d_ty * d_qp_x;
      edge_val = edge_sum[EW-1:0];
   end

   // Weight multiply for the interpolation numerator.
   logic [DEPTH_BITS-1:0] mul_z;
   logic [EW-2:0]         mul_w;
   logic [PW-1:0]         mul_p;

   always_comb begin
      case (cmd.idx)
         trdt_pkg::STEP_W'(1): begin
            mul_z = vz_ff[1];
            mul_w = e_ff[1][EW-2:0];
         end
         trdt_pkg::STEP_W'(2): begin
            mul_z = vz_ff[2];
            mul_w = e_ff[2][EW-2:0];
         end
         default: begin
            mul_z = vz_ff[0];
            mul_w = e_ff[0][EW-2:0];
         end
      endcase
      mul_p = mul_z * mul_w;
   end

   // One quotient bit per cycle against the shifted total.
   logic [NW-1:0] div_sh;
   assign div_sh = NW'(total_ff[EW-2:0]) << cmd.idx;

   // Store address.
   logic [AW:0]   addr_sum;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [trdt_pkg::COLOR_W-1:0] mem_wcolor;
   logic [DEPTH_BITS-1:0]        mem_wdepth;
   logic          nearer;

   assign addr_sum   = {1'b0, row_base_ff} + (AW + 1)'(px_ff);
   assign mem_addr   = (cmd.op == trdt_pkg::OP_CLEAR) ? clr_ff : addr_sum[AW-1:0];
   assign nearer     = q_ff < rd_depth_ff;
   assign mem_we     = (cmd.op == trdt_pkg::OP_CLEAR) || (cmd.op == trdt_pkg::OP_TEST && nearer);
   assign mem_wcolor = color_ff;
   assign mem_wdepth = (cmd.op == trdt_pkg::OP_CLEAR) ? far_ff : q_ff;

   logic [trdt_pkg::COLOR_W-1:0] color_mem [STORE];
   logic [DEPTH_BITS-1:0]        depth_mem [STORE];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         color_mem[mem_addr] <= mem_wcolor;
         depth_mem[mem_addr] <= mem_wdepth;
      end
      rd_color_ff <= color_mem[mem_addr];
      rd_depth_ff <= depth_mem[mem_addr];
   end

   // Main datapath registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         trdt_pkg::OP_LOAD: begin
            code_ff  <= req_command;
            vx_ff[0] <= req_ax;
            vy_ff[0] <= req_ay;
            vz_ff[0] <= req_az;
            vx_ff[1] <= req_bx;
            vy_ff[1] <= req_by_row;
            vz_ff[1] <= req_bz;
            vx_ff[2] <= req_cx;
            vy_ff[2] <= req_cy;
            vz_ff[2] <= req_cz;
            color_ff <= req_fill_color;
            count_ff <= '0;
            clr_ff   <= '0;
         end
         trdt_pkg::OP_BOX: begin
            w_ff    <= wact;
            h_ff    <= hact;
            minx_ff <= bminx;
            miny_ff <= bminy;
            maxx_ff <= bmaxx_c;
            maxy_ff <= bmaxy_c;
            // A read walks nothing; its pixel sits at the first vertex.
            px_ff   <= (code_ff == trdt_pkg::CMD_DRAW) ? bminx : vx_ff[0];
            py_ff   <= (code_ff == trdt_pkg::CMD_DRAW) ? bminy : vy_ff[0];
         end
         trdt_pkg::OP_SETUP: begin
            case (cmd.idx)
               trdt_pkg::STEP_W'(0): begin
                  total_ff    <= edge_val;
                  row_base_ff <= AW'(py_ff) * AW'(w_ff);
               end
               trdt_pkg::STEP_W'(1): begin
                  e_ff[0]    <= edge_val;
                  erow_ff[0] <= edge_val;
               end
               trdt_pkg::STEP_W'(2): begin
                  e_ff[1]    <= edge_val;
                  erow_ff[1] <= edge_val;
               end
               default: begin
                  e_ff[2]    <= edge_val;
                  erow_ff[2] <= edge_val;
               end
            endcase
         end
         trdt_pkg::OP_PIX: begin
            acc_ff <= '0;
            q_ff   <= '0;
         end
         trdt_pkg::OP_MUL: begin
            acc_ff <= acc_ff + NW'(mul_p);
         end
         trdt_pkg::OP_DIV: begin
            if (acc_ff >= div_sh) begin
               acc_ff <= acc_ff - div_sh;
               q_ff   <= q_ff | (DEPTH_BITS'(1) << cmd.idx);
            end
         end
         trdt_pkg::OP_TEST: begin
            if (nearer) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         trdt_pkg::OP_STEP: begin
            if (px_ff == maxx_ff) begin
               if (py_ff != maxy_ff) begin
                  py_ff       <= py_ff + 1'b1;
                  px_ff       <= minx_ff;
                  row_base_ff <= row_base_ff + AW'(w_ff);
                  for (int i = 0; i < 3; i++) begin
                     erow_ff[i] <= erow_ff[i] + dys[i];
                     e_ff[i]    <= erow_ff[i] + dys[i];
                  end
               end
            end else begin
               px_ff <= px_ff + 1'b1;
               for (int i = 0; i < 3; i++) begin
                  e_ff[i] <= e_ff[i] + dxs[i];
               end
            end
         end
         trdt_pkg::OP_CLEAR: begin
            clr_ff <= clr_ff + 1'b1;
         end
         trdt_pkg::OP_RSP: begin
            rsp_pixels_written <= count_ff;
            if (code_ff == trdt_pkg::CMD_READ && status.rd_ok) begin
               rsp_read_color <= rd_color_ff;
               rsp_read_depth <= rd_depth_ff;
            end else begin
               rsp_read_color <= '0;
               rsp_read_depth <= '0;
            end
         end
         default: ;
      endcase
   end

   assign status.code    = code_ff;
   assign status.skip    = (w_ff == '0) || (h_ff == '0) || total_ff[EW-1] || (total_ff == '0)
                           || (minx_ff > maxx_ff) || (miny_ff > maxy_ff);
   assign status.rd_ok   = (px_ff < w_ff) && (py_ff < h_ff);
   assign status.covered = !e_ff[0][EW-1] && !e_ff[1][EW-1] && !e_ff[2][EW-1];
   assign status.row_end = (px_ff == maxx_ff);
   assign status.box_end = (py_ff == maxy_ff);
   assign status.clr_end = (clr_ff == CLR_LAST);

endmodule
